[src/mrupr_pkg.sv]
// Package for the MRU page replacement unit: shared constants, widths and
// the control/status structs passed between the top level and the frame cells.
// No dependencies.
package mrupr_pkg;

	localparam int FRAMES_DEF    = 8;
	localparam int PAGE_BITS_DEF = 16;

	localparam int PAGE_NUM_W = 16;   // width of the page_number field
	localparam int CFG_W      = 4;    // width of frames_in_use
	localparam int SLOT_OUT_W = 3;    // width of frame_slot
	localparam int TOTAL_W    = 32;   // width of the hit/fault totals

	localparam logic [CFG_W-1:0]   FRAMES_IN_USE_RST = CFG_W'(8);
	localparam logic [TOTAL_W-1:0] TOTAL_MAX         = '1;

	// per-cell control from the top level
	typedef struct packed {
		logic searched;   // cell lies below the filled, active frame count
		logic wr_en;      // cell takes the current page this cycle
	} cell_ctl_t;

	// per-cell status back to the top level and the next cell
	typedef struct packed {
		logic first_hit;  // lowest searched cell holding the page
		logic taken;      // a match exists in this cell or one before it
	} cell_stat_t;

endpackage

[src/mrupr_ifs.sv]
// Valid/ready channel interfaces of the MRU page replacement unit:
// reference requests, results and the frames_in_use write channel.
// Depends on mrupr_pkg.
interface mrupr_req_if;
	logic                               valid;
	logic                               ready;
	logic [mrupr_pkg::PAGE_NUM_W-1:0]   page_number;

	modport source (output valid, output page_number, input ready);
	modport sink   (input valid, input page_number, output ready);
endinterface

interface mrupr_rsp_if;
	logic                               valid;
	logic                               ready;
	logic                               was_hit;
	logic [mrupr_pkg::SLOT_OUT_W-1:0]   frame_slot;
	logic [mrupr_pkg::TOTAL_W-1:0]      hit_total;
	logic [mrupr_pkg::TOTAL_W-1:0]      fault_total;

	modport source (output valid, output was_hit, output frame_slot,
		output hit_total, output fault_total, input ready);
	modport sink   (input valid, input was_hit, input frame_slot,
		input hit_total, input fault_total, output ready);
endinterface

interface mrupr_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [mrupr_pkg::CFG_W-1:0]        frames_in_use;

	modport source (output valid, output frames_in_use, input ready);
	modport sink   (input valid, input frames_in_use, output ready);
endinterface

[src/mrupr_cell.sv]
// One frame cell of the MRU page replacement unit: holds a resident page,
// compares it with the broadcast reference and extends the priority chain.
// Depends on mrupr_pkg.
module mrupr_cell #(
	parameter int PAGE_BITS = mrupr_pkg::PAGE_BITS_DEF
) (
	input  logic                     clk,
	input  mrupr_pkg::cell_ctl_t     ctl,
	input  logic [PAGE_BITS-1:0]     page,
	input  logic                     taken_in,
	output mrupr_pkg::cell_stat_t    stat
);
	import mrupr_pkg::*;

	logic [PAGE_BITS-1:0] page_q;
	logic                 match;

	// contents undefined until written; only searched cells are ever read
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			page_q <= page;
		end
	end

	assign match          = ctl.searched && (page_q == page);
	assign stat.first_hit = match && !taken_in;
	assign stat.taken     = match || taken_in;

endmodule

[src/mru_page_replacement_unit.sv]
// MRU page replacement unit, top level: request register, row of frame
// cells, fill/victim control, saturating totals and result register.
// Depends on mrupr_pkg, mrupr_ifs and mrupr_cell.
// Path: request register, then result register; a stall on the result side holds both.
// Throughput: one reference per cycle while the result side does not stall; the cell row compares and writes together.
// Reset: control, fill count, recent frame and totals clear; frames_in_use goes
// to 8. Frame contents are undefined until filled; no clearing pass is needed.
module mru_page_replacement_unit #(
	parameter int FRAMES    = mrupr_pkg::FRAMES_DEF,
	parameter int PAGE_BITS = mrupr_pkg::PAGE_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	mrupr_cfg_if.sink     cfg,
	mrupr_req_if.sink     req,
	mrupr_rsp_if.source   rsp
);
	import mrupr_pkg::*;

	localparam int SLOT_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int FILL_W = $clog2(FRAMES + 1);
	localparam int CMP_W  = (FILL_W > CFG_W) ? FILL_W : CFG_W;
	localparam logic [CMP_W-1:0] FRAMES_C = CMP_W'(FRAMES);

	// configuration
	logic [CFG_W-1:0]     frames_in_use_q;

	// request stage
	logic                 valid_s1;
	logic [PAGE_BITS-1:0] page_s1;
	logic [PAGE_BITS-1:0] page_in;
	logic                 advance;

	// replacement state
	logic [FILL_W-1:0]    filled_q;
	logic [SLOT_W-1:0]    recent_q;
	logic [TOTAL_W-1:0]   hit_cnt_q;
	logic [TOTAL_W-1:0]   fault_cnt_q;

	// result register
	logic                 rsp_valid_q;
	logic                 was_hit_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [TOTAL_W-1:0]   hit_total_q;
	logic [TOTAL_W-1:0]   fault_total_q;

	// lookup
	logic [CMP_W-1:0]     n_act;
	logic [CMP_W-1:0]     fill_act;
	logic                 hit;
	logic                 do_ref;
	logic [SLOT_W-1:0]    hit_slot;
	logic [SLOT_W-1:0]    slot;
	logic [TOTAL_W-1:0]   hit_next;
	logic [TOTAL_W-1:0]   fault_next;

	cell_ctl_t            ctl  [FRAMES];
	cell_stat_t           stat [FRAMES];

	// config is always taken; the channel must be written only while idle (the unit does not enforce this)
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_in_use_q <= FRAMES_IN_USE_RST;
		end else if (cfg.valid) begin
			frames_in_use_q <= cfg.frames_in_use;
		end
	end

	// page number is cut or zero-extended to PAGE_BITS
	generate
		if (PAGE_BITS <= PAGE_NUM_W) begin : g_pg_cut
			assign page_in = req.page_number[PAGE_BITS-1:0];
		end else begin : g_pg_ext
			assign page_in = {{(PAGE_BITS-PAGE_NUM_W){1'b0}}, req.page_number};
		end
	endgenerate

	// stage 1 moves on whenever the result register is free or being drained
	assign advance   = !rsp_valid_q || rsp.ready;
	assign req.ready = !valid_s1 || advance;
	assign do_ref    = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			page_s1 <= page_in;
		end
	end

	// active frame count: zero acts as one, anything above FRAMES as FRAMES
	always_comb begin
		n_act = CMP_W'(frames_in_use_q);
		if (n_act == '0) begin
			n_act = CMP_W'(1);
		end
		if (n_act > FRAMES_C) begin
			n_act = FRAMES_C;
		end
		// after a shrink the extra filled frames simply drop out of the search
		fill_act = (CMP_W'(filled_q) < n_act) ? CMP_W'(filled_q) : n_act;
	end

	// cell row: page broadcast, first-match priority ripples down the chain
	generate
		for (genvar g = 0; g < FRAMES; g++) begin : g_cell
			logic taken_in;
			if (g == 0) begin : g_head
				assign taken_in = 1'b0;
			end else begin : g_link
				assign taken_in = stat[g-1].taken;
			end

			assign ctl[g].searched = CMP_W'(g) < fill_act;
			assign ctl[g].wr_en    = do_ref && !hit && (slot == SLOT_W'(g));

			mrupr_cell #(
				.PAGE_BITS (PAGE_BITS)
			) u_cell (
				.clk      (clk),
				.ctl      (ctl[g]),
				.page     (page_s1),
				.taken_in (taken_in),
				.stat     (stat[g])
			);
		end
	endgenerate

	assign hit = stat[FRAMES-1].taken;

	// one-hot first match to index
	always_comb begin
		hit_slot = '0;
		for (int i = 0; i < FRAMES; i++) begin
			if (stat[i].first_hit) begin
				hit_slot = hit_slot | SLOT_W'(i);
			end
		end
	end

	// frame choice: hit frame, else first free frame, else the recent frame
	// (the last active frame if the recent one now lies outside the count)
	always_comb begin
		if (hit) begin
			slot = hit_slot;
		end else if (fill_act < n_act) begin
			slot = fill_act[SLOT_W-1:0];
		end else if (CMP_W'(recent_q) < n_act) begin
			slot = recent_q;
		end else begin
			slot = SLOT_W'(n_act - CMP_W'(1));
		end
	end

	assign hit_next   = (hit && hit_cnt_q != TOTAL_MAX) ? hit_cnt_q + 1'b1 : hit_cnt_q;
	assign fault_next = (!hit && fault_cnt_q != TOTAL_MAX) ?
		fault_cnt_q + 1'b1 : fault_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q    <= '0;
			recent_q    <= '0;
			hit_cnt_q   <= '0;
			fault_cnt_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (do_ref) begin
				recent_q    <= slot;
				hit_cnt_q   <= hit_next;
				fault_cnt_q <= fault_next;
				if (!hit && fill_act < n_act) begin
					filled_q <= FILL_W'(fill_act + CMP_W'(1));
				end
			end
			if (advance) begin
				rsp_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_ref) begin
			was_hit_q     <= hit;
			slot_q        <= slot;
			hit_total_q   <= hit_next;
			fault_total_q <= fault_next;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.was_hit     = was_hit_q;
	assign rsp.hit_total   = hit_total_q;
	assign rsp.fault_total = fault_total_q;

	generate
		if (SLOT_W >= SLOT_OUT_W) begin : g_slot_cut
			assign rsp.frame_slot = slot_q[SLOT_OUT_W-1:0];
		end else begin : g_slot_ext
			assign rsp.frame_slot = {{(SLOT_OUT_W-SLOT_W){1'b0}}, slot_q};
		end
	endgenerate

endmodule

[src/mrupr_checker.sv]
// Port-level checks for the MRU page replacement unit, attached by bind.
// Depends on mrupr_pkg and mru_page_replacement_unit.
module mrupr_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              rsp_valid,
	input logic                              rsp_ready,
	input logic                              was_hit,
	input logic [mrupr_pkg::SLOT_OUT_W-1:0]  frame_slot,
	input logic [mrupr_pkg::TOTAL_W-1:0]     hit_total,
	input logic [mrupr_pkg::TOTAL_W-1:0]     fault_total
);
	import mrupr_pkg::*;

	// no result may show while reset is held
	a_rst_quiet: assert property (@(posedge clk) !arst_n |-> !rsp_valid)
		else $error("result valid during reset");

	// a hit result carries a hit total that counts it
	a_hit_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && was_hit) |-> (hit_total != '0))
		else $error("hit reported with zero hit total");

	// a fault result carries a fault total that counts it
	a_fault_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !was_hit) |-> (fault_total != '0))
		else $error("fault reported with zero fault total");

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(was_hit) &&
		$stable(frame_slot) && $stable(hit_total) && $stable(fault_total)))
		else $error("stalled result changed");

endmodule

bind mru_page_replacement_unit mrupr_checker u_mrupr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.was_hit     (rsp.was_hit),
	.frame_slot  (rsp.frame_slot),
	.hit_total   (rsp.hit_total),
	.fault_total (rsp.fault_total)
);

[tb/tb_top.sv]
// Self-checking testbench for mru_page_replacement_unit: page references in,
// hit/fault results out, each checked against an in-bench MRU frame table.
// Depends on mrupr_pkg, mrupr_ifs and the unit's RTL.
`timescale 1ns / 100ps

module tb_top;
	import mrupr_pkg::*;

	localparam int FRAMES         = 8;
	localparam int PAGE_BITS      = 16;
	localparam int SETTLE_CYCLES  = 8;     // extra wait after the last owed result arrives
	localparam int WATCHDOG_LIMIT = 2000;  // far above the longest legal silence

	// one result transaction as the unit should present it
	typedef struct packed {
		logic                   was_hit;
		logic [SLOT_OUT_W-1:0]  frame_slot;
		logic [TOTAL_W-1:0]     hit_total;
		logic [TOTAL_W-1:0]     fault_total;
	} page_outcome_t;

	logic clk;
	logic arst_n;

	mrupr_cfg_if cfg_ch ();
	mrupr_req_if req_ch ();
	mrupr_rsp_if rsp_ch ();

	mru_page_replacement_unit #(
		.FRAMES    (FRAMES),
		.PAGE_BITS (PAGE_BITS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// ------------------------------------------------------------------
	// Frame table mirror: page per frame, fill level, last touched frame,
	// saturating totals and the frames_in_use register as last written.
	// ------------------------------------------------------------------
	logic [PAGE_BITS-1:0]  frame_pages [FRAMES];
	int unsigned           frames_filled  = 0;
	int unsigned           last_frame     = 0;
	logic [TOTAL_W-1:0]    hits_so_far    = '0;
	logic [TOTAL_W-1:0]    faults_so_far  = '0;
	logic [CFG_W-1:0]      frames_setting = FRAMES_IN_USE_RST;

	// results owed by the unit, oldest first
	page_outcome_t due_outcomes [$];

	int unsigned fail_count   = 0;
	int unsigned refs_sent    = 0;
	int unsigned results_seen = 0;
	int unsigned hits_seen    = 0;
	int unsigned cfg_writes   = 0;
	int unsigned idle_cycles  = 0;
	int unsigned send_quiet   = 0;
	int unsigned recv_quiet   = 0;

	// Apply one reference to the mirror and return what the unit must report.
	function automatic page_outcome_t resolve_reference(input logic [PAGE_NUM_W-1:0] page);
		int unsigned   active;
		int unsigned   present;
		int unsigned   slot;
		logic          hit;
		page_outcome_t res;
		// frames_in_use of 0 behaves as 1; anything past the row size is clamped
		active = frames_setting;
		if (active == 0) begin
			active = 1;
		end
		if (active > FRAMES) begin
			active = FRAMES;
		end
		// after a shrink the fill level stays put, but only active frames count
		present = (frames_filled < active) ? frames_filled : active;
		hit  = 1'b0;
		slot = 0;
		for (int i = 0; i < present; i++) begin
			if (!hit && frame_pages[i] == page[PAGE_BITS-1:0]) begin
				hit  = 1'b1;
				slot = i;
			end
		end
		if (hit) begin
			if (hits_so_far != TOTAL_MAX) begin
				hits_so_far++;
			end
		end else begin
			if (present < active) begin
				slot          = present;
				frames_filled = present + 1;
			end else begin
				// MRU victim; if that frame is now outside the active set, take the top one
				slot = (last_frame < active) ? last_frame : active - 1;
			end
			frame_pages[slot] = page[PAGE_BITS-1:0];
			if (faults_so_far != TOTAL_MAX) begin
				faults_so_far++;
			end
		end
		last_frame      = slot;
		res.was_hit     = hit;
		res.frame_slot  = SLOT_OUT_W'(slot);
		res.hit_total   = hits_so_far;
		res.fault_total = faults_so_far;
		return res;
	endfunction

	// Idle length for either side: mostly none, some short, a few long,
	// with occasional quiet stretches where neither side holds back at all.
	function automatic int unsigned pick_pause(inout int unsigned quiet);
		int unsigned r;
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			quiet = $urandom_range(20, 80);
			return 0;
		end
		if (r < 60) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(6, 30);
	endfunction

	task automatic report_mismatch(input string what);
		fail_count++;
		$display("[%0t] MISMATCH: %s", $time, what);
	endtask

	// ------------------------------------------------------------------
	// Clock, reset, and known values on every input from time zero
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result side back-pressure. Ready drops for a random stall, then holds
	// high at least one cycle; only one assignment per edge.
	initial begin
		int unsigned stall;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			stall = pick_pause(recv_quiet);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Result checker: every result transaction is matched against the
	// oldest owed outcome, field by field. Sampled at the edge, so the
	// values seen are the ones the handshake qualified.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		page_outcome_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			results_seen++;
			if (rsp_ch.was_hit) begin
				hits_seen++;
			end
			if (due_outcomes.size() == 0) begin
				report_mismatch($sformatf("result with no reference outstanding (slot %0d)",
					rsp_ch.frame_slot));
			end else begin
				want = due_outcomes.pop_front();
				if (rsp_ch.was_hit !== want.was_hit)
					report_mismatch($sformatf("was_hit %b, expected %b",
						rsp_ch.was_hit, want.was_hit));
				if (rsp_ch.frame_slot !== want.frame_slot)
					report_mismatch($sformatf("frame_slot %0d, expected %0d",
						rsp_ch.frame_slot, want.frame_slot));
				if (rsp_ch.hit_total !== want.hit_total)
					report_mismatch($sformatf("hit_total %0d, expected %0d",
						rsp_ch.hit_total, want.hit_total));
				if (rsp_ch.fault_total !== want.fault_total)
					report_mismatch($sformatf("fault_total %0d, expected %0d",
						rsp_ch.fault_total, want.fault_total));
			end
		end
	end

	// Watchdog: any transaction on any channel resets the count; a long
	// silence means a hang (lost result, stuck ready).
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[%0t] watchdog: no transaction for %0d cycles, %0d results owed",
				$time, idle_cycles, due_outcomes.size());
			$display("mru_page_replacement_unit verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Shared drivers
	// ------------------------------------------------------------------

	// One reference transaction. Valid is left high on return so that
	// back-to-back references need no extra edge; the next call drops it
	// only if it wants a gap.
	task automatic send_ref(input logic [PAGE_NUM_W-1:0] page);
		int unsigned gap;
		gap = pick_pause(send_quiet);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.page_number <= page;
		do @(posedge clk); while (!req_ch.ready);
		due_outcomes.push_back(resolve_reference(page));
		refs_sent++;
	endtask

	// Stop sending and wait until every owed result has arrived, then a
	// few cycles more so nothing is left in flight.
	task automatic hold_until_drained();
		req_ch.valid <= 1'b0;
		while (due_outcomes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// frames_in_use write, only with the unit idle
	task automatic write_frames(input logic [CFG_W-1:0] count);
		hold_until_drained();
		cfg_ch.valid         <= 1'b1;
		cfg_ch.frames_in_use <= count;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		frames_setting = count;
		cfg_writes++;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset setting of 8 frames: fill all of them, both extreme page numbers included, with a hit
	// on page 0000, then a fault on a full table replaces the last touched frame.
	task automatic test_fill_and_replace();
		logic [PAGE_NUM_W-1:0] pages [11] = '{16'h0000, 16'hFFFF, 16'h0000, 16'h1234,
			16'h5678, 16'hAAAA, 16'h5555, 16'h00FF, 16'hFF00, 16'h8001, 16'h8001};
		foreach (pages[i]) begin
			send_ref(pages[i]);
		end
	endtask

	// A count of 0 runs one frame (recent frame 7 is out of range, so frame 0
	// is the victim); a count of 15 runs all 8 and sees the old contents.
	task automatic test_frame_count_limits();
		write_frames(4'd0);
		send_ref(16'h4321);
		send_ref(16'h4321);
		write_frames(4'd15);
		send_ref(16'hFFFF);
		send_ref(16'h8001);
	endtask

	// Shrink while the recent frame sits above the new count: the fault goes
	// to the top active frame. Growing back exposes frames filled earlier.
	task automatic test_shrink_and_regrow();
		write_frames(4'd8);
		send_ref(16'h00FF);
		write_frames(4'd3);
		send_ref(16'h7777);
		send_ref(16'h7777);
		write_frames(4'd8);
		send_ref(16'h8001);
	endtask

	// Phases of random references under different frame counts. Most pages
	// come from a small per-phase working set so hits and MRU replacement
	// both happen often; the rest are arbitrary 16-bit pages.
	task automatic test_random_traffic();
		logic [CFG_W-1:0]      plan [8] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd9, 4'd2, 4'd8};
		logic [PAGE_NUM_W-1:0] working_set [16];
		int unsigned           set_len;
		logic [CFG_W-1:0]      count;
		for (int phase = 0; phase < 16; phase++) begin
			count = (phase < 8) ? plan[phase] : CFG_W'($urandom_range(0, 15));
			write_frames(count);
			set_len = $urandom_range(1, 16);
			foreach (working_set[i]) begin
				working_set[i] = PAGE_NUM_W'($urandom_range(0, 65535));
			end
			for (int n = 0; n < 75; n++) begin
				if ($urandom_range(0, 99) < 85)
					send_ref(working_set[$urandom_range(0, set_len - 1)]);
				else
					send_ref(PAGE_NUM_W'($urandom_range(0, 65535)));
				// now and then let the pipe empty completely mid-phase
				if ($urandom_range(0, 99) < 2)
					hold_until_drained();
			end
		end
	endtask

	task automatic finish_run();
		hold_until_drained();
		$display("covered %0d references over %0d frame-count writes (0, 1, 8 and 15 included)",
			refs_sent, cfg_writes);
		$display("checked %0d results, %0d hits and %0d faults", results_seen, hits_seen,
			results_seen - hits_seen);
		if (fail_count == 0) begin
			$display("mru_page_replacement_unit verification clean");
		end else begin
			$display("mru_page_replacement_unit verification failed");
		end
		$finish;
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n               <= 1'b0;
		req_ch.valid         <= 1'b0;
		req_ch.page_number   <= '0;
		cfg_ch.valid         <= 1'b0;
		cfg_ch.frames_in_use <= FRAMES_IN_USE_RST;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_fill_and_replace();
		test_frame_count_limits();
		test_shrink_and_regrow();
		test_random_traffic();
		finish_run();
	end

endmodule
